>>> hw/rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg: shared types and constants of the signed 32-bit ALU
// Operation and error codes, pipeline stage record and the divider step.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 4;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned ErrW    = 2;
  // Input stage, multiply stage, one stage per quotient bit, output stage.
  localparam int unsigned NumStages = DataW + 3;
  localparam int unsigned DivFirst  = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_EQ  = 4'd5,
    OP_NE  = 4'd6,
    OP_LT  = 4'd7,
    OP_GT  = 4'd8,
    OP_LE  = 4'd9,
    OP_GE  = 4'd10,
    OP_NEG = 4'd11,
    OP_SHL = 4'd12,
    OP_SHR = 4'd13
  } alu_op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_INVALID  = 2'd2
  } alu_err_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ErrW-1:0]  err;
    logic [DataW-1:0] res;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] quo;   // dividend magnitude shifts out, quotient shifts in
    logic [DataW-1:0] rem;
    logic [DataW-1:0] dvs;   // divisor magnitude
    logic             neg_q;
    logic             neg_r;
  } stage_t;

  // One restoring division step: one quotient bit.
  function automatic stage_t div_step(stage_t s);
    stage_t         o;
    logic [DataW:0] part;
    logic [DataW:0] diff;
    o    = s;
    part = {s.rem, s.quo[DataW-1]};
    diff = part - {1'b0, s.dvs};
    if (!diff[DataW]) begin
      o.rem = diff[DataW-1:0];
      o.quo = {s.quo[DataW-2:0], 1'b1};
    end else begin
      o.rem = part[DataW-1:0];
      o.quo = {s.quo[DataW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/sia_req_if.sv
// ----------------------------------------------------------------------------
// sia_req_if: request channel of the signed 32-bit ALU
// Valid/ready channel carrying the operation and its operands.
// ----------------------------------------------------------------------------
interface sia_req_if;
  logic                              valid;
  logic                              ready;
  logic [sia_pkg::OpW-1:0]           operation;
  logic signed [sia_pkg::DataW-1:0]  left_operand;
  logic signed [sia_pkg::DataW-1:0]  right_operand;
  logic [sia_pkg::ShiftW-1:0]        shift_amount;

  modport source (output valid, operation, left_operand, right_operand, shift_amount,
                  input ready);
  modport sink (input valid, operation, left_operand, right_operand, shift_amount,
                output ready);
endinterface

>>> hw/rtl/sia_rsp_if.sv
// ----------------------------------------------------------------------------
// sia_rsp_if: response channel of the signed 32-bit ALU
// Valid/ready channel carrying the result and the error code.
// ----------------------------------------------------------------------------
interface sia_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [sia_pkg::DataW-1:0]  result_value;
  logic [sia_pkg::ErrW-1:0]          error_code;

  modport source (output valid, result_value, error_code, input ready);
  modport sink (input valid, result_value, error_code, output ready);
endinterface

>>> hw/rtl/signed_int32_alu.sv
// ----------------------------------------------------------------------------
// signed_int32_alu: pipelined 32-bit two's-complement ALU
// Add, subtract, multiply, divide, remainder, compares, negate and shifts.
// ----------------------------------------------------------------------------
// The ALU takes one operation per cycle unless the pipeline holds. Every
// operation goes through the same 35 register stages: an input stage, a
// multiply stage, 32 restoring divider stages that produce one quotient bit
// each, and an output register. The whole pipeline holds while a finished
// result is not taken, so nothing is lost or repeated.
module signed_int32_alu (
  input  logic  clk_i,
  input  logic  rst_ni,
  sia_req_if.sink   req_i,
  sia_rsp_if.source rsp_o
);
  import sia_pkg::*;

  logic [NumStages-1:0] valid_q;
  stage_t               stage_q [NumStages];
  stage_t               stage_d [NumStages];
  logic                 advance;
  logic                 in_fire;

  assign advance     = !valid_q[NumStages-1] || rsp_o.ready;
  assign req_i.ready = advance;
  assign in_fire     = req_i.valid && advance;

  always_comb begin
    stage_t           s_in;
    stage_t           s_mul;
    stage_t           s_out;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    // Input stage: simple operations, operand magnitudes and sign fixes.
    s_in       = '0;
    a          = req_i.left_operand;
    b          = req_i.right_operand;
    s_in.op    = req_i.operation;
    s_in.a     = a;
    s_in.b     = b;
    s_in.err   = ERR_NONE;
    s_in.quo   = a[DataW-1] ? (~a + 1'b1) : a;
    s_in.dvs   = b[DataW-1] ? (~b + 1'b1) : b;
    s_in.rem   = '0;
    s_in.neg_q = a[DataW-1] ^ b[DataW-1];
    s_in.neg_r = a[DataW-1];
    case (alu_op_e'(req_i.operation))
      OP_ADD: s_in.res = a + b;
      OP_SUB: s_in.res = a - b;
      OP_MUL: s_in.res = '0;
      OP_DIV, OP_REM: begin
        if (b == '0) s_in.err = ERR_DIV_ZERO;
      end
      OP_EQ:  s_in.res = {{(DataW-1){1'b0}}, a == b};
      OP_NE:  s_in.res = {{(DataW-1){1'b0}}, a != b};
      OP_LT:  s_in.res = {{(DataW-1){1'b0}}, $signed(a) < $signed(b)};
      OP_GT:  s_in.res = {{(DataW-1){1'b0}}, $signed(a) > $signed(b)};
      OP_LE:  s_in.res = {{(DataW-1){1'b0}}, $signed(a) <= $signed(b)};
      OP_GE:  s_in.res = {{(DataW-1){1'b0}}, $signed(a) >= $signed(b)};
      OP_NEG: s_in.res = ~a + 1'b1;
      OP_SHL: s_in.res = a << req_i.shift_amount;
      OP_SHR: s_in.res = $unsigned($signed(a) >>> req_i.shift_amount);
      default: s_in.err = ERR_INVALID;
    endcase
    stage_d[0] = s_in;

    // Multiply stage, then one quotient bit per stage.
    s_mul = stage_q[0];
    if (alu_op_e'(s_mul.op) == OP_MUL) s_mul.res = s_mul.a * s_mul.b;
    stage_d[1] = s_mul;
    for (int i = DivFirst; i < NumStages - 1; i++) begin
      stage_d[i] = div_step(stage_q[i-1]);
    end

    // Output stage: sign the quotient or remainder, clear results on error.
    s_out = stage_q[NumStages-2];
    if (alu_op_e'(s_out.op) == OP_DIV) s_out.res = s_out.neg_q ? (~s_out.quo + 1'b1) : s_out.quo;
    if (alu_op_e'(s_out.op) == OP_REM) s_out.res = s_out.neg_r ? (~s_out.rem + 1'b1) : s_out.rem;
    if (s_out.err != ERR_NONE) s_out.res = '0;
    stage_d[NumStages-1] = s_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[NumStages-2:0], in_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < NumStages; i++) stage_q[i] <= stage_d[i];
    end
  end

  assign rsp_o.valid        = valid_q[NumStages-1];
  assign rsp_o.result_value = stage_q[NumStages-1].res;
  assign rsp_o.error_code   = stage_q[NumStages-1].err;

endmodule

>>> hw/rtl/sia_checker.sv
// ----------------------------------------------------------------------------
// sia_checker: port-level checks of the signed 32-bit ALU
// Response stability under stall, error results and input flow.
// ----------------------------------------------------------------------------
module sia_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [sia_pkg::DataW-1:0]         result_value_i,
  input logic [sia_pkg::ErrW-1:0]          error_code_i
);
  import sia_pkg::*;

  // A stalled response stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response valid dropped during stall");

  // A stalled response keeps its payload.
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(result_value_i) && $stable(error_code_i))
    else $error("response payload changed during stall");

  // An error transfer carries a zero result.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && error_code_i != ERR_NONE |-> result_value_i == '0)
    else $error("nonzero result with error");

  // The pipeline only holds off new requests while a result is waiting.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i || rsp_ready_i |-> req_ready_i)
    else $error("request stalled without a waiting result");

endmodule

bind signed_int32_alu sia_checker u_sia_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .result_value_i (rsp_o.result_value),
  .error_code_i   (rsp_o.error_code)
);
